// ===== src/sensor_voltage_to_mixture_class_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SENSOR_VOLTAGE_TO_MIXTURE_CLASS_ASSERT_SVH
`define SENSOR_VOLTAGE_TO_MIXTURE_CLASS_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SVMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svmc check failed");

// Next-cycle implication, disabled while reset is active.
`define SVMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svmc check failed");

`endif

// ===== src/svmc_pkg.sv =====
`timescale 1ns / 1ps

package svmc_pkg;

    // Field widths
    localparam int MV_W   = 13;
    localparam int DIFF_W = MV_W + 1;
    localparam int IDX_W  = 8;
    localparam int CLS_W  = 3;
    localparam int QUO_W  = 7;
    localparam int NUM_W  = MV_W + QUO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MV_W;

    // Queue depth between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // Index saturates at this magnitude
    localparam logic [QUO_W-1:0] IDX_MAX_MAG = 7'd100;

    // Reset calibration
    localparam logic [MV_W-1:0]         RST_VOLT_LEAN_END = 13'd100;
    localparam logic [MV_W-1:0]         RST_VOLT_RICH_END = 13'd900;
    localparam logic [MV_W-1:0]         RST_VOLT_STOICH   = 13'd450;
    localparam logic signed [IDX_W-1:0] RST_LIM_VERY_LEAN = -8'sd50;
    localparam logic signed [IDX_W-1:0] RST_LIM_LEAN      = -8'sd10;
    localparam logic signed [IDX_W-1:0] RST_LIM_RICH      = 8'sd10;
    localparam logic signed [IDX_W-1:0] RST_LIM_VERY_RICH = 8'sd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLT_LEAN_END = 3'd0,
        REG_VOLT_RICH_END = 3'd1,
        REG_VOLT_STOICH   = 3'd2,
        REG_LIM_VERY_LEAN = 3'd3,
        REG_LIM_LEAN      = 3'd4,
        REG_LIM_RICH      = 3'd5,
        REG_LIM_VERY_RICH = 3'd6
    } reg_idx_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_VERY_LEAN = 3'd0,
        CLS_LEAN      = 3'd1,
        CLS_STOICH    = 3'd2,
        CLS_RICH      = 3'd3,
        CLS_VERY_RICH = 3'd4
    } mix_class_t;

    typedef struct packed {
        logic [MV_W-1:0]         volt_lean_end;
        logic [MV_W-1:0]         volt_rich_end;
        logic [MV_W-1:0]         volt_stoich;
        logic signed [IDX_W-1:0] lim_very_lean;
        logic signed [IDX_W-1:0] lim_lean;
        logic signed [IDX_W-1:0] lim_rich;
        logic signed [IDX_W-1:0] lim_very_rich;
    } cfg_t;

    // One prepared division job
    typedef struct packed {
        logic [MV_W-1:0] mag_diff;
        logic [MV_W-1:0] mag_den;
        logic            neg;
        logic            den_zero;
    } job_t;

endpackage

// ===== src/sensor_voltage_to_mixture_class.sv =====
`timescale 1ns / 1ps
// Oxygen-sensor voltage to mixture index and class.
// s_axis: one item per sensor sample, tdata[12:0] = sample_mv (mV).
// m_axis: one item per sample, tdata[7:0] = mixture_index (signed, -100..100),
//         tdata[10:8] = mixture_class (0 very lean .. 4 very rich).
// cfg: write-only register port; cfg_index selects the calibration register,
//      cfg_data carries the value (limits use the low 8 bits). Always ready.
//      Write only while no sample is in flight.
// Throughput: one item per cycle while the output is not stalled. The divider
// is seven restoring stages, one quotient bit each, behind a times-100 stage
// and a saturation check. Path from input accept to m_axis_tvalid: queue,
// scale, saturation check, 7 divider steps, clamp, output register.
// Stall: with m_axis_tvalid high and m_axis_tready low the back pipe freezes;
// the front keeps taking items into a FIFO_DEPTH-entry queue and drops
// s_axis_tready once full. Reset: clears the queue and all pipeline valids
// and loads the default calibration (100, 900, 450 mV; limits -50, -10, 10, 50).
module sensor_voltage_to_mixture_class #(
    parameter int FIFO_DEPTH = svmc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [12:0] sample_mv
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [7:0] mixture_index,
                                                           // [10:8] mixture_class
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [svmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import svmc_pkg::*;

    cfg_t             cfg;
    job_t             wr_job;
    job_t             rd_job;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] out_index;
    logic [CLS_W-1:0] out_class;

    assign m_axis_tdata = {(16 - IDX_W - CLS_W)'(0), out_class, out_index};

    svmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svmc_front u_front (
        .sample_valid (s_axis_tvalid),
        .sample_mv    (s_axis_tdata[MV_W-1:0]),
        .cfg          (cfg),
        .push         (push),
        .full         (full),
        .ready        (s_axis_tready),
        .job          (wr_job)
    );

    svmc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .rd_job (rd_job)
    );

    svmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .job       (rd_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_class (out_class)
    );

endmodule

// ===== src/svmc_cfg.sv =====
`timescale 1ns / 1ps

module svmc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [svmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svmc_pkg::CFG_DATA_W-1:0] cfg_data,
    output svmc_pkg::cfg_t                 cfg
);
    import svmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_VOLT_LEAN_END: cfg_next.volt_lean_end = cfg_data;
                REG_VOLT_RICH_END: cfg_next.volt_rich_end = cfg_data;
                REG_VOLT_STOICH:   cfg_next.volt_stoich   = cfg_data;
                REG_LIM_VERY_LEAN: cfg_next.lim_very_lean = cfg_data[IDX_W-1:0];
                REG_LIM_LEAN:      cfg_next.lim_lean      = cfg_data[IDX_W-1:0];
                REG_LIM_RICH:      cfg_next.lim_rich      = cfg_data[IDX_W-1:0];
                REG_LIM_VERY_RICH: cfg_next.lim_very_rich = cfg_data[IDX_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_lean_end <= RST_VOLT_LEAN_END;
            cfg_reg.volt_rich_end <= RST_VOLT_RICH_END;
            cfg_reg.volt_stoich   <= RST_VOLT_STOICH;
            cfg_reg.lim_very_lean <= RST_LIM_VERY_LEAN;
            cfg_reg.lim_lean      <= RST_LIM_LEAN;
            cfg_reg.lim_rich      <= RST_LIM_RICH;
            cfg_reg.lim_very_rich <= RST_LIM_VERY_RICH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/svmc_front.sv =====
`timescale 1ns / 1ps

module svmc_front (
    input  logic                      sample_valid,
    input  logic [svmc_pkg::MV_W-1:0] sample_mv,
    input  svmc_pkg::cfg_t            cfg,
    output logic                      push,
    input  logic                      full,
    output logic                      ready,
    output svmc_pkg::job_t            job
);
    import svmc_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] den;
    logic                     low_seg;

    assign ready = !full;
    assign push  = sample_valid && !full;

    // Pick the segment and its divisor
    always_comb
    begin
        diff    = $signed({1'b0, sample_mv}) - $signed({1'b0, cfg.volt_stoich});
        low_seg = (sample_mv <= cfg.volt_stoich);
        if (low_seg)
        begin
            den = $signed({1'b0, cfg.volt_stoich}) - $signed({1'b0, cfg.volt_lean_end});
        end
        else
        begin
            den = $signed({1'b0, cfg.volt_rich_end}) - $signed({1'b0, cfg.volt_stoich});
        end
    end

    // Split into magnitudes and a result sign
    always_comb
    begin
        job.mag_diff = diff[DIFF_W-1] ? MV_W'(-diff) : diff[MV_W-1:0];
        job.mag_den  = den[DIFF_W-1]  ? MV_W'(-den)  : den[MV_W-1:0];
        job.neg      = diff[DIFF_W-1] ^ den[DIFF_W-1];
        job.den_zero = (den == '0);
    end

endmodule

// ===== src/svmc_fifo.sv =====
`timescale 1ns / 1ps

module svmc_fifo #(
    parameter int DEPTH = svmc_pkg::FIFO_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  svmc_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output svmc_pkg::job_t rd_job
);
    import svmc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== src/svmc_back.sv =====
`timescale 1ns / 1ps

module svmc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  svmc_pkg::cfg_t              cfg,
    input  logic                        empty,
    input  svmc_pkg::job_t              job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [svmc_pkg::IDX_W-1:0]  out_index,
    output logic [svmc_pkg::CLS_W-1:0]  out_class
);
    import svmc_pkg::*;

    logic en;

    // Scale stage
    logic             mul_vld_reg;
    logic [NUM_W-1:0] mul_num_reg;
    logic [MV_W-1:0]  mul_den_reg;
    logic             mul_neg_reg;
    logic             mul_zero_reg;
    logic [NUM_W-1:0] mul_num_next;

    // Divider stages: entry 0 is the saturation check, entry j the j-th quotient bit
    logic             div_vld_reg  [0:QUO_W];
    logic [NUM_W-1:0] div_rem_reg  [0:QUO_W];
    logic [QUO_W-1:0] div_q_reg    [0:QUO_W];
    logic [MV_W-1:0]  div_den_reg  [0:QUO_W];
    logic             div_neg_reg  [0:QUO_W];
    logic             div_zero_reg [0:QUO_W];
    logic             div_sat_reg  [0:QUO_W];

    // Clamp stage
    logic                    cl_vld_reg;
    logic signed [IDX_W-1:0] cl_idx_reg;
    logic [QUO_W-1:0]        cl_mag;
    logic signed [IDX_W-1:0] cl_idx_next;

    // Output register
    logic                    out_vld_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    mix_class_t              out_cls_reg;
    mix_class_t              out_cls_next;

    // Whole pipe moves when the output slot is free or being taken
    assign en        = !out_vld_reg || out_ready;
    assign pop       = en && !empty;
    assign out_valid = out_vld_reg;
    assign out_index = out_idx_reg;
    assign out_class = out_cls_reg;

    // Times 100 as shifts and adds
    assign mul_num_next = (NUM_W'(job.mag_diff) << 6) + (NUM_W'(job.mag_diff) << 5)
                        + (NUM_W'(job.mag_diff) << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_vld_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_num_reg  <= mul_num_next;
            mul_den_reg  <= job.mag_den;
            mul_neg_reg  <= job.neg;
            mul_zero_reg <= job.den_zero;
        end
    end

    // Flag quotients of 128 and above
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg[0] <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_rem_reg[0]  <= mul_num_reg;
            div_q_reg[0]    <= '0;
            div_den_reg[0]  <= mul_den_reg;
            div_neg_reg[0]  <= mul_neg_reg;
            div_zero_reg[0] <= mul_zero_reg;
            div_sat_reg[0]  <= (mul_num_reg >= (NUM_W'(mul_den_reg) << QUO_W));
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_div
        localparam int K = QUO_W - j;
        logic [NUM_W-1:0] shifted;
        logic             ge;

        assign shifted = NUM_W'(div_den_reg[j-1]) << K;
        assign ge      = (div_rem_reg[j-1] >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                div_vld_reg[j] <= div_vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_reg[j]  <= ge ? div_rem_reg[j-1] - shifted : div_rem_reg[j-1];
                div_q_reg[j]    <= div_q_reg[j-1] | (QUO_W'(ge) << K);
                div_den_reg[j]  <= div_den_reg[j-1];
                div_neg_reg[j]  <= div_neg_reg[j-1];
                div_zero_reg[j] <= div_zero_reg[j-1];
                div_sat_reg[j]  <= div_sat_reg[j-1];
            end
        end
    end

    // Clamp, zero divisor, apply sign
    always_comb
    begin
        if (div_sat_reg[QUO_W] || (div_q_reg[QUO_W] > IDX_MAX_MAG))
        begin
            cl_mag = IDX_MAX_MAG;
        end
        else
        begin
            cl_mag = div_q_reg[QUO_W];
        end
        if (div_zero_reg[QUO_W])
        begin
            cl_idx_next = '0;
        end
        else if (div_neg_reg[QUO_W])
        begin
            cl_idx_next = -$signed({1'b0, cl_mag});
        end
        else
        begin
            cl_idx_next = $signed({1'b0, cl_mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            cl_vld_reg <= div_vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_idx_reg <= cl_idx_next;
        end
    end

    // Sort into classes, lowest threshold first
    always_comb
    begin
        if (cl_idx_reg < cfg.lim_very_lean)
        begin
            out_cls_next = CLS_VERY_LEAN;
        end
        else if (cl_idx_reg < cfg.lim_lean)
        begin
            out_cls_next = CLS_LEAN;
        end
        else if (cl_idx_reg < cfg.lim_rich)
        begin
            out_cls_next = CLS_STOICH;
        end
        else if (cl_idx_reg < cfg.lim_very_rich)
        begin
            out_cls_next = CLS_RICH;
        end
        else
        begin
            out_cls_next = CLS_VERY_RICH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= cl_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_idx_reg <= cl_idx_reg;
            out_cls_reg <= out_cls_next;
        end
    end

endmodule

// ===== src/svmc_checker.sv =====
`timescale 1ns / 1ps
`include "sensor_voltage_to_mixture_class_assert.svh"

module svmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import svmc_pkg::*;

    // Index stays inside the clamp range
    `SVMC_ASSERT_IMP(a_idx_range, clk, rst_n, m_axis_tvalid, ($signed(m_axis_tdata[7:0]) >= -8'sd100) && ($signed(m_axis_tdata[7:0]) <= 8'sd100))

    // Class is one of the five codes and pad bits stay zero
    `SVMC_ASSERT_IMP(a_cls_code, clk, rst_n, m_axis_tvalid, (m_axis_tdata[10:8] <= CLS_VERY_RICH) && (m_axis_tdata[15:11] == 5'd0))

    // A stalled result holds
    `SVMC_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sensor_voltage_to_mixture_class svmc_checker u_svmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_sensor_voltage_to_mixture_class.sv =====
`timescale 1ns / 1ps

module tb_sensor_voltage_to_mixture_class;
    import svmc_pkg::*;

    // Index beyond the register map; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 16;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {CAL_DEFAULT, CAL_ZERO, CAL_FULL, CAL_ORDERED, CAL_WILD} cal_mode_t;

    typedef struct {
        logic signed [IDX_W-1:0] mix_index;
        mix_class_t              cls;
    } mixture_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  addr;
        logic [MV_W-1:0]       data;
        bit                    typed;
        mixture_t              want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t      cal;
    mixture_t  expected_mixtures[$];
    row_t      directed[$];
    cal_mode_t phase_plan[NUM_PHASES] = '{CAL_ORDERED, CAL_ZERO, CAL_WILD,
                                          CAL_FULL, CAL_DEFAULT, CAL_ORDERED};
    bit        idle_on;
    int        errors;

    sensor_voltage_to_mixture_class dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [12:0] sample_mv
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] mixture_index, [10:8] mixture_class
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Interpolate on the active segment, clamp, then classify
    function automatic mixture_t predict_mixture(input logic [MV_W-1:0] mv);
        int       v;
        int       mid;
        int       num;
        int       den;
        int       q;
        mixture_t r;
        v   = int'(mv);
        mid = int'(cal.volt_stoich);
        num = (v - mid) * 100;
        if (v <= mid)
            den = mid - int'(cal.volt_lean_end);
        else
            den = int'(cal.volt_rich_end) - mid;
        q = (den != 0) ? num / den : 0;
        if (q < -100)
            q = -100;
        if (q > 100)
            q = 100;
        r.mix_index = q[IDX_W-1:0];
        if (q < $signed(cal.lim_very_lean))
            r.cls = CLS_VERY_LEAN;
        else if (q < $signed(cal.lim_lean))
            r.cls = CLS_LEAN;
        else if (q < $signed(cal.lim_rich))
            r.cls = CLS_STOICH;
        else if (q < $signed(cal.lim_very_rich))
            r.cls = CLS_RICH;
        else
            r.cls = CLS_VERY_RICH;
        return r;
    endfunction

    // Limit in the low byte, random junk above it
    function automatic logic [MV_W-1:0] limit_word(input int lim);
        logic [4:0] junk;
        logic [7:0] low;
        junk = 5'($urandom_range(0, 31));
        low  = lim[7:0];
        return {junk, low};
    endfunction

    // Mostly in-range voltages, some near a calibration point, some full width
    function automatic logic [MV_W-1:0] pick_sample();
        int pick;
        int base;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            v = $urandom_range(0, 5000);
            return v[MV_W-1:0];
        end
        if (pick < 80)
        begin
            case ($urandom_range(0, 2))
                0: base = int'(cal.volt_lean_end);
                1: base = int'(cal.volt_stoich);
                default: base = int'(cal.volt_rich_end);
            endcase
            v = base + int'($urandom_range(0, 16)) - 8;
            if (v < 0)
                v = 0;
            if (v > 8191)
                v = 8191;
            return v[MV_W-1:0];
        end
        v = $urandom_range(0, 8191);
        return v[MV_W-1:0];
    endfunction

    task automatic add_sample(input logic [MV_W-1:0] mv);
        row_t r;
        r.is_cfg = 1'b0;
        r.addr   = '0;
        r.data   = mv;
        r.typed  = 1'b0;
        r.want.mix_index = '0;
        r.want.cls       = CLS_STOICH;
        directed.push_back(r);
    endtask

    task automatic add_typed(input logic [MV_W-1:0] mv, input int idx, input mix_class_t cls);
        row_t r;
        r.is_cfg = 1'b0;
        r.addr   = '0;
        r.data   = mv;
        r.typed  = 1'b1;
        r.want.mix_index = idx[IDX_W-1:0];
        r.want.cls       = cls;
        directed.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] addr, input logic [MV_W-1:0] data);
        row_t r;
        r.is_cfg = 1'b1;
        r.addr   = addr;
        r.data   = data;
        r.typed  = 1'b0;
        r.want.mix_index = '0;
        r.want.cls       = CLS_STOICH;
        directed.push_back(r);
    endtask

    // Offer one item, hold until accepted, then queue its expected result
    task automatic send_sample(input logic [MV_W-1:0] mv, input bit typed,
                               input mixture_t want);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, mv};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            expected_mixtures.push_back(want);
        else
            expected_mixtures.push_back(predict_mixture(mv));
    endtask

    // Stop offering items and wait until the pipeline is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_mixtures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [MV_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            REG_VOLT_LEAN_END: cal.volt_lean_end = data;
            REG_VOLT_RICH_END: cal.volt_rich_end = data;
            REG_VOLT_STOICH:   cal.volt_stoich   = data;
            REG_LIM_VERY_LEAN: cal.lim_very_lean = data[IDX_W-1:0];
            REG_LIM_LEAN:      cal.lim_lean      = data[IDX_W-1:0];
            REG_LIM_RICH:      cal.lim_rich      = data[IDX_W-1:0];
            REG_LIM_VERY_RICH: cal.lim_very_rich = data[IDX_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Load a whole calibration set, plus one write to the unused index
    task automatic apply_calibration(input cal_mode_t mode);
        logic [MV_W-1:0] lean;
        logic [MV_W-1:0] mid;
        logic [MV_W-1:0] rich;
        int vl;
        int l;
        int r;
        int vr;
        case (mode)
            CAL_DEFAULT:
            begin
                lean = RST_VOLT_LEAN_END;
                mid  = RST_VOLT_STOICH;
                rich = RST_VOLT_RICH_END;
                vl   = RST_LIM_VERY_LEAN;
                l    = RST_LIM_LEAN;
                r    = RST_LIM_RICH;
                vr   = RST_LIM_VERY_RICH;
            end
            CAL_ZERO:
            begin
                lean = '0;
                mid  = '0;
                rich = '0;
                vl   = -128;
                l    = -128;
                r    = -128;
                vr   = -128;
            end
            CAL_FULL:
            begin
                lean = '1;
                mid  = '1;
                rich = '1;
                vl   = 127;
                l    = 127;
                r    = 127;
                vr   = 127;
            end
            CAL_ORDERED:
            begin
                lean = MV_W'($urandom_range(0, 2000));
                mid  = MV_W'($urandom_range(int'(lean), 3000));
                rich = MV_W'($urandom_range(int'(mid), 5000));
                vl   = int'($urandom_range(0, 60)) - 100;
                l    = vl + int'($urandom_range(0, 40));
                r    = l + int'($urandom_range(0, 60));
                vr   = r + int'($urandom_range(0, 60));
            end
            default:
            begin
                lean = MV_W'($urandom_range(0, 8191));
                mid  = MV_W'($urandom_range(0, 8191));
                rich = MV_W'($urandom_range(0, 8191));
                vl   = int'($urandom_range(0, 255)) - 128;
                l    = int'($urandom_range(0, 255)) - 128;
                r    = int'($urandom_range(0, 255)) - 128;
                vr   = int'($urandom_range(0, 255)) - 128;
            end
        endcase
        write_reg(REG_VOLT_LEAN_END, lean);
        write_reg(REG_VOLT_RICH_END, rich);
        write_reg(REG_VOLT_STOICH, mid);
        write_reg(REG_LIM_VERY_LEAN, limit_word(vl));
        write_reg(REG_LIM_LEAN, limit_word(l));
        write_reg(REG_LIM_RICH, limit_word(r));
        write_reg(REG_LIM_VERY_RICH, limit_word(vr));
        write_reg(REG_NONE, MV_W'($urandom_range(0, 8191)));
    endtask

    // Stall the result side in bursts, with calm stretches between
    initial
    begin
        m_axis_tready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Compare every accepted result with the oldest expected mixture
    initial
    begin
        mixture_t want;
        errors = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_mixtures.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: index %0d class %0d",
                                 $signed(m_axis_tdata[7:0]), m_axis_tdata[10:8]);
                end
                else
                begin
                    want = expected_mixtures.pop_front();
                    if (m_axis_tdata[7:0] !== want.mix_index ||
                        m_axis_tdata[10:8] !== want.cls)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("mismatch: index exp %0d got %0d, class exp %0d got %0d",
                                     want.mix_index, $signed(m_axis_tdata[7:0]),
                                     want.cls, m_axis_tdata[10:8]);
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        mixture_t none;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        idle_on        = 1'b1;
        none.mix_index = '0;
        none.cls       = CLS_STOICH;
        cal.volt_lean_end = RST_VOLT_LEAN_END;
        cal.volt_rich_end = RST_VOLT_RICH_END;
        cal.volt_stoich   = RST_VOLT_STOICH;
        cal.lim_very_lean = RST_LIM_VERY_LEAN;
        cal.lim_lean      = RST_LIM_LEAN;
        cal.lim_rich      = RST_LIM_RICH;
        cal.lim_very_rich = RST_LIM_VERY_RICH;

        // Reset calibration: ends of the scale, zero point, overrange
        add_typed(13'd0, -100, CLS_VERY_LEAN);
        add_typed(13'd100, -100, CLS_VERY_LEAN);
        add_typed(13'd450, 0, CLS_STOICH);
        add_typed(13'd900, 100, CLS_VERY_RICH);
        add_typed(13'h1FFF, 100, CLS_VERY_RICH);
        add_sample(13'd250);
        add_sample(13'd400);
        add_sample(13'd451);
        add_sample(13'd500);
        add_sample(13'd700);
        add_sample(13'd5000);
        // Lean segment of zero width
        add_cfg(REG_VOLT_LEAN_END, 13'd450);
        add_typed(13'd0, 0, CLS_STOICH);
        add_typed(13'd450, 0, CLS_STOICH);
        add_sample(13'd675);
        // Rich segment of zero width
        add_cfg(REG_VOLT_RICH_END, 13'd450);
        add_typed(13'h1FFF, 0, CLS_STOICH);
        // Calibration out of order: negative divisors on both sides
        add_cfg(REG_VOLT_LEAN_END, 13'd1000);
        add_cfg(REG_VOLT_RICH_END, 13'd200);
        add_sample(13'd0);
        add_sample(13'd449);
        add_sample(13'd5000);
        // Write to an unused index must leave the calibration alone
        add_cfg(REG_NONE, 13'h1FFF);
        add_sample(13'd5000);
        // Thresholds out of order, with junk above the low byte
        add_cfg(REG_LIM_VERY_LEAN, 13'h1F7F);
        add_cfg(REG_LIM_LEAN, 13'h0080);
        add_cfg(REG_LIM_RICH, 13'h1F00);
        add_cfg(REG_LIM_VERY_RICH, 13'h0080);
        add_sample(13'd0);
        add_sample(13'd449);
        add_sample(13'd5000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed rows; drain before any register write
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed[i].addr, directed[i].data);
            end
            else
                send_sample(directed[i].data, directed[i].typed, directed[i].want);
        end

        // Random phases, each under a fresh calibration; last one runs flat out
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            apply_calibration(phase_plan[p]);
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(pick_sample(), 1'b0, none);
        end

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sensor_voltage_to_mixture_class.f =====
+incdir+src
src/svmc_pkg.sv
src/svmc_cfg.sv
src/svmc_front.sv
src/svmc_fifo.sv
src/svmc_back.sv
src/sensor_voltage_to_mixture_class.sv
src/svmc_checker.sv
tb/tb_sensor_voltage_to_mixture_class.sv
